// ===== hdl/fbpm_pkg.sv =====
// fbpm_pkg: shared types and constants for the fixed buffer pool manager
// no dependencies; imported by every module of the block
`default_nettype none

package fbpm_pkg;

   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int REQ_LEN_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_APPEND = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_ALLOC = 2'd2
   } status_type;

   // decoded request as it travels from front end to back end
   typedef struct packed {
      kind_type op;
      logic     in_range;
   } req_class_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/fbpm_front.sv =====
// fbpm_front: request acceptance and classification into the request queue
// depends on fbpm_pkg
`default_nettype none

module fbpm_front #(
   parameter int NUM_BUFFERS = 64,
   parameter int IDW         = 6
) (
   input  wire logic                           start,
   output      logic                           busy,
   input  wire logic [fbpm_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [IDW-1:0]                 req_buffer_id,
   input  wire logic [fbpm_pkg::REQ_LEN_W-1:0] req_append_len,
   input  wire logic                           q_full,
   output      logic                           q_push,
   output      fbpm_pkg::req_class_type        q_cls,
   output      logic [IDW-1:0]                 q_id,
   output      logic [fbpm_pkg::REQ_LEN_W-1:0] q_len
);
   import fbpm_pkg::*;

   always_comb begin
      busy            = q_full;
      q_push          = start && !q_full;
      q_cls.op        = kind_type'(req_kind);
      // ids past the pool size count as never allocated
      q_cls.in_range  = ((IDW+1)'(req_buffer_id) < (IDW+1)'(NUM_BUFFERS));
      q_id            = req_buffer_id;
      q_len           = req_append_len;
   end

endmodule

`default_nettype wire

// ===== hdl/fbpm_queue.sv =====
// fbpm_queue: two-entry request queue between front end and back end
// depends on fbpm_pkg
`default_nettype none

module fbpm_queue #(
   parameter int IDW = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire fbpm_pkg::req_class_type        push_cls,
   input  wire logic [IDW-1:0]                 push_id,
   input  wire logic [fbpm_pkg::REQ_LEN_W-1:0] push_len,
   input  wire logic                           pop,
   output      logic                           full,
   output      logic                           empty,
   output      fbpm_pkg::req_class_type        head_cls,
   output      logic [IDW-1:0]                 head_id,
   output      logic [fbpm_pkg::REQ_LEN_W-1:0] head_len
);
   import fbpm_pkg::*;

   localparam int DEPTH = 2;

   req_class_type              cls_ff [DEPTH];
   logic [IDW-1:0]             id_ff  [DEPTH];
   logic [REQ_LEN_W-1:0]       len_ff [DEPTH];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'(DEPTH));
      empty     = (count_ff == 2'd0);
      head_cls  = cls_ff[rd_ptr_ff];
      head_id   = id_ff[rd_ptr_ff];
      head_len  = len_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cls_ff[wr_ptr_ff] <= push_cls;
         id_ff[wr_ptr_ff]  <= push_id;
         len_ff[wr_ptr_ff] <= push_len;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/fbpm_back.sv =====
// fbpm_back: executes requests against the free stack, in-use bits and fill lengths
// depends on fbpm_pkg; holds the free stack and fill length memories
`default_nettype none

module fbpm_back #(
   parameter int NUM_BUFFERS  = 64,
   parameter int BUFFER_BYTES = 2048,
   parameter int IDW          = 6,
   parameter int CNTW         = 7,
   parameter int LENW         = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_empty,
   input  wire fbpm_pkg::req_class_type        q_cls,
   input  wire logic [IDW-1:0]                 q_id,
   input  wire logic [fbpm_pkg::REQ_LEN_W-1:0] q_len,
   output      logic                           q_pop,
   output      logic                           rsp_valid,
   output      logic [fbpm_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [IDW-1:0]                 rsp_granted_id,
   output      logic [LENW-1:0]                rsp_write_offset,
   output      logic [LENW-1:0]                rsp_copied_len,
   output      logic [CNTW-1:0]                rsp_free_count
);
   import fbpm_pkg::*;

   localparam int SLOTS = 1 << IDW;
   localparam int CMPW  = (LENW > REQ_LEN_W) ? LENW : REQ_LEN_W;

   logic [IDW-1:0]   stack_mem [SLOTS];
   logic [LENW-1:0]  fill_mem  [SLOTS];

   back_state_type   state_ff, state_in;
   logic [CNTW-1:0]  top_ff, top_in;
   // stack entries below the low mark were never written and still hold their index
   logic [CNTW-1:0]  low_ff, low_in;
   logic [SLOTS-1:0] in_use_ff, in_use_in;

   req_class_type    cur_cls_ff;
   logic [IDW-1:0]   cur_id_ff;
   logic [REQ_LEN_W-1:0] cur_len_ff;
   logic [IDW-1:0]   stack_rd_ff;
   logic             stack_fresh_ff;
   logic [LENW-1:0]  fill_rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [IDW-1:0]   granted_ff, granted_in;
   logic [LENW-1:0]  offset_ff, offset_in;
   logic [LENW-1:0]  copied_ff, copied_in;
   logic [CNTW-1:0]  count_ff, count_in;

   logic [CNTW-1:0]  top_dec;
   logic [IDW-1:0]   stack_ra;
   logic [IDW-1:0]   pop_id;
   logic             id_alloc;
   logic [CMPW-1:0]  fill_x, room, want, take;
   logic             stack_we, fill_we;
   logic [IDW-1:0]   stack_wa, fill_wa;
   logic [IDW-1:0]   stack_wd;
   logic [LENW-1:0]  fill_wd;

   always_comb begin
      top_dec   = top_ff - CNTW'(1);
      stack_ra  = top_dec[IDW-1:0];
      pop_id    = stack_fresh_ff ? stack_ra : stack_rd_ff;
      id_alloc  = cur_cls_ff.in_range && in_use_ff[cur_id_ff];
      fill_x    = CMPW'(fill_rd_ff);
      room      = (fill_x < CMPW'(BUFFER_BYTES)) ? CMPW'(BUFFER_BYTES) - fill_x : '0;
      want      = CMPW'(cur_len_ff);
      take      = (want < room) ? want : room;

      state_in     = state_ff;
      top_in       = top_ff;
      low_in       = low_ff;
      in_use_in    = in_use_ff;
      q_pop        = 1'b0;
      stack_we     = 1'b0;
      stack_wa     = top_ff[IDW-1:0];
      stack_wd     = cur_id_ff;
      fill_we      = 1'b0;
      fill_wa      = cur_id_ff;
      fill_wd      = '0;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      granted_in   = granted_ff;
      offset_in    = offset_ff;
      copied_in    = copied_ff;
      count_in     = count_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in     = BK_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            granted_in   = '0;
            offset_in    = '0;
            copied_in    = '0;
            case (cur_cls_ff.op)
               KIND_ALLOC: begin
                  if (top_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     top_in            = top_dec;
                     low_in            = (top_dec < low_ff) ? top_dec : low_ff;
                     in_use_in[pop_id] = 1'b1;
                     fill_we           = 1'b1;
                     fill_wa           = pop_id;
                     fill_wd           = '0;
                     granted_in        = pop_id;
                  end
               end
               KIND_FREE: begin
                  if (!id_alloc || top_ff >= CNTW'(NUM_BUFFERS)) begin
                     status_in = ST_NOT_ALLOC;
                  end else begin
                     in_use_in[cur_id_ff] = 1'b0;
                     stack_we             = 1'b1;
                     top_in               = top_ff + CNTW'(1);
                  end
               end
               KIND_APPEND: begin
                  if (!id_alloc) begin
                     status_in = ST_NOT_ALLOC;
                  end else begin
                     fill_we   = 1'b1;
                     fill_wd   = LENW'(fill_x + take);
                     offset_in = fill_rd_ff;
                     copied_in = LENW'(take);
                  end
               end
               default: begin
               end
            endcase
            count_in = top_in;
         end
         default: state_in = BK_IDLE;
      endcase

      rsp_valid        = rsp_valid_ff;
      rsp_status       = status_ff;
      rsp_granted_id   = granted_ff;
      rsp_write_offset = offset_ff;
      rsp_copied_len   = copied_ff;
      rsp_free_count   = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         top_ff       <= CNTW'(NUM_BUFFERS);
         low_ff       <= CNTW'(NUM_BUFFERS);
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         low_ff       <= low_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
      copied_ff  <= copied_in;
      count_ff   <= count_in;
      if (q_pop) begin
         cur_cls_ff     <= q_cls;
         cur_id_ff      <= q_id;
         cur_len_ff     <= q_len;
         stack_rd_ff    <= stack_mem[stack_ra];
         stack_fresh_ff <= (top_ff <= low_ff);
         fill_rd_ff     <= fill_mem[q_id];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (fill_we) begin
         fill_mem[fill_wa] <= fill_wd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/fixed_buffer_pool_manager_top.sv =====
// fixed_buffer_pool_manager_top: lifo buffer pool allocator, front end, queue and back end
// depends on fbpm_pkg, fbpm_front, fbpm_queue, fbpm_back
//
//   channel   direction  handshake              payload
//   request   in         start high, busy low   req_kind, req_buffer_id, req_append_len
//   result    out        rsp_valid, one cycle   rsp_status, rsp_granted_id,
//                                               rsp_write_offset, rsp_copied_len,
//                                               rsp_free_count
//
// the back end handles each request as a registered read of the free stack and fill
// length memories, then an update, and takes no new request until that update is
// done; when idle a request passes the queue entry, the back end's read registers
// and the result registers before its result is on the ports.
// a two-entry queue takes requests while the back end works; busy is the queue full.
// results cannot be held off. synchronous reset returns all buffers to the pool
// with no clearing pass.
`default_nettype none

module fixed_buffer_pool_manager_top #(
   parameter int NUM_BUFFERS  = 64,
   parameter int BUFFER_BYTES = 2048
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   output      logic                                        busy,
   input  wire logic [fbpm_pkg::KIND_W-1:0]                 req_kind,
   input  wire logic [$clog2(NUM_BUFFERS)-1:0]              req_buffer_id,
   input  wire logic [fbpm_pkg::REQ_LEN_W-1:0]              req_append_len,
   output      logic                                        rsp_valid,
   output      logic [fbpm_pkg::STATUS_W-1:0]               rsp_status,
   output      logic [$clog2(NUM_BUFFERS)-1:0]              rsp_granted_id,
   output      logic [$clog2(BUFFER_BYTES+1)-1:0]           rsp_write_offset,
   output      logic [$clog2(BUFFER_BYTES+1)-1:0]           rsp_copied_len,
   output      logic [$clog2(NUM_BUFFERS+1)-1:0]            rsp_free_count
);
   import fbpm_pkg::*;

   localparam int IDW  = $clog2(NUM_BUFFERS);
   localparam int CNTW = $clog2(NUM_BUFFERS + 1);
   localparam int LENW = $clog2(BUFFER_BYTES + 1);

   logic                 q_full, q_empty, q_push, q_pop;
   req_class_type        push_cls, head_cls;
   logic [IDW-1:0]       push_id, head_id;
   logic [REQ_LEN_W-1:0] push_len, head_len;

   fbpm_front #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .IDW         (IDW)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_buffer_id  (req_buffer_id),
      .req_append_len (req_append_len),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cls          (push_cls),
      .q_id           (push_id),
      .q_len          (push_len)
   );

   fbpm_queue #(
      .IDW (IDW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cls (push_cls),
      .push_id  (push_id),
      .push_len (push_len),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cls (head_cls),
      .head_id  (head_id),
      .head_len (head_len)
   );

   fbpm_back #(
      .NUM_BUFFERS  (NUM_BUFFERS),
      .BUFFER_BYTES (BUFFER_BYTES),
      .IDW          (IDW),
      .CNTW         (CNTW),
      .LENW         (LENW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_cls            (head_cls),
      .q_id             (head_id),
      .q_len            (head_len),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_write_offset (rsp_write_offset),
      .rsp_copied_len   (rsp_copied_len),
      .rsp_free_count   (rsp_free_count)
   );

   // the back end never returns results on consecutive cycles
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_count <= CNTW'(NUM_BUFFERS)))
      else $error("free count beyond pool size");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_free_count == '0 && rsp_granted_id == '0))
      else $error("empty pool result inconsistent");

   // a pop from the queue always follows an entry that was pushed earlier
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule

`default_nettype wire
